// ----- hdl/hfpt_pkg.sv -----
// ----------------------------------------------------------------------------
// hfpt_pkg
// Types, register codes and constants shared by the hashed-feature
// perceptron trainer, its checker and its testbench.
// ----------------------------------------------------------------------------
package hfpt_pkg;

  localparam int unsigned DIMENSION_DEF    = 65536;
  localparam int unsigned MAX_FEATURES_DEF = 1024;

  localparam int unsigned IndexW  = 16;
  localparam int unsigned WeightW = 32;
  localparam int unsigned ScoreW  = 48;
  localparam int unsigned CountW  = 32;
  localparam int unsigned StepW   = 24;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = StepW;

  localparam logic [CfgIdxW-1:0] REG_TRAIN_ENABLE = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_UPDATE_STEP  = 1'd1;

  localparam logic             TRAIN_ENABLE_RST = 1'b1;
  localparam logic [StepW-1:0] UPDATE_STEP_RST  = 24'd1973;

  // one half in Q16.16
  localparam logic signed [ScoreW-1:0] HALF_Q16 = 48'sd32768;

  typedef struct packed {
    logic [IndexW-1:0] feature_index;
    logic              label;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic                     predicted;
    logic                     mistake;
    logic [CountW-1:0]        error_count;
    logic                     overflow;
  } out_item_t;

endpackage

// ----- hdl/hfpt_ram.sv -----
// ----------------------------------------------------------------------------
// hfpt_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module hfpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/hashed_feature_perceptron_trainer_unit.sv -----
// ----------------------------------------------------------------------------
// hashed_feature_perceptron_trainer_unit
// Online perceptron over hashed features: scores each example from a weight
// memory and, in training mode, replays its buffered features to update them.
// ----------------------------------------------------------------------------
// Sequence: a feature transaction with index below DIMENSION has its weight
//   read, then accumulated; an index at or above DIMENSION first passes
//   through the modulo steps and one re-read. The last feature then forms
//   the result, and a training-mode mistake replays each buffered feature
//   in turn (buffer read, weight read, weight write).
// Reset: a clearing pass zeroes the whole weight RAM; input stays stalled
//   meanwhile, configuration writes are taken throughout.
module hashed_feature_perceptron_trainer_unit #(
  parameter int unsigned DIMENSION    = hfpt_pkg::DIMENSION_DEF,
  parameter int unsigned MAX_FEATURES = hfpt_pkg::MAX_FEATURES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hfpt_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hfpt_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [hfpt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hfpt_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW    = $clog2(DIMENSION);
  localparam int unsigned IDXW  = (AW < hfpt_pkg::IndexW) ? AW : hfpt_pkg::IndexW;
  localparam int unsigned BW    = $clog2(MAX_FEATURES);
  localparam int unsigned CW    = $clog2(MAX_FEATURES + 1);
  localparam int unsigned MOD_STEPS =
      (DIMENSION >= 65536) ? 1 : $clog2(65536 / DIMENSION) + 1;
  localparam int unsigned MKW   = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int unsigned WW    = hfpt_pkg::WeightW;
  localparam int unsigned SW    = hfpt_pkg::ScoreW;

  localparam logic [39:0]    DIM_W     = 40'(DIMENSION);
  localparam logic [AW-1:0]  CLR_LAST  = AW'(DIMENSION - 1);
  localparam logic [CW-1:0]  CNT_MAX   = CW'(MAX_FEATURES);
  localparam logic [MKW-1:0] MOD_FIRST = MKW'(MOD_STEPS - 1);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_MOD  = 4'd2;
  localparam logic [3:0] ST_RD   = 4'd3;
  localparam logic [3:0] ST_ACC  = 4'd4;
  localparam logic [3:0] ST_FIN  = 4'd5;
  localparam logic [3:0] ST_UBUF = 4'd6;
  localparam logic [3:0] ST_UWRD = 4'd7;
  localparam logic [3:0] ST_UWWR = 4'd8;

  logic [3:0]                          state_q, state_d;
  logic [AW-1:0]                       clr_addr_q, clr_addr_d;
  logic [hfpt_pkg::IndexW-1:0]         idx_q, idx_d;
  logic                                label_q, label_d;
  logic                                last_q, last_d;
  logic [MKW-1:0]                      mod_k_q, mod_k_d;
  logic signed [SW-1:0]                score_q, score_d;
  logic [CW-1:0]                       cnt_q, cnt_d;
  logic [CW-1:0]                       upd_i_q, upd_i_d;
  logic [AW-1:0]                       upd_addr_q, upd_addr_d;
  logic                                ovf_q, ovf_d;
  logic                                step_up_q, step_up_d;
  logic [hfpt_pkg::CountW-1:0]         total_q, total_d;
  logic                                train_en_q;
  logic [hfpt_pkg::StepW-1:0]          step_q;
  logic                                out_valid_q, out_valid_d;
  hfpt_pkg::out_item_t                 out_item_q, out_item_d;

  // weight RAM
  logic                                w_we;
  logic [AW-1:0]                       w_waddr, w_raddr;
  logic [WW-1:0]                       w_wdata, w_rdata;
  // feature buffer
  logic                                b_we;
  logic [IDXW-1:0]                     b_rdata;

  logic                                in_acc;
  logic                                out_acc;
  logic [39:0]                         mod_div;
  logic                                mod_ge;
  logic signed [SW:0]                  score_sum;
  logic signed [SW-1:0]                score_sat;
  logic signed [WW:0]                  w_sum;
  logic signed [WW:0]                  step_s;
  logic signed [WW-1:0]                w_sat;
  logic                                pred;
  logic                                mistake;

  assign in_acc  = in_valid_i && (state_q == ST_IDLE);
  assign out_acc = out_valid_q && !out_stall_i;

  // modulo by DIMENSION: one shifted compare and subtract per cycle
  assign mod_div = DIM_W << mod_k_q;
  assign mod_ge  = {24'd0, idx_q} >= mod_div;

  assign score_sum = (SW + 1)'(score_q) + (SW + 1)'($signed(w_rdata));
  always_comb begin
    if (score_sum[SW] != score_sum[SW-1]) begin
      score_sat = score_sum[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
    end else begin
      score_sat = score_sum[SW-1:0];
    end
  end

  assign step_s = step_up_q ? (WW + 1)'($signed({1'b0, step_q}))
                            : -(WW + 1)'($signed({1'b0, step_q}));
  assign w_sum  = (WW + 1)'($signed(w_rdata)) + step_s;
  always_comb begin
    if (w_sum[WW] != w_sum[WW-1]) begin
      w_sat = w_sum[WW] ? {1'b1, {(WW - 1){1'b0}}} : {1'b0, {(WW - 1){1'b1}}};
    end else begin
      w_sat = w_sum[WW-1:0];
    end
  end

  assign pred    = score_q > hfpt_pkg::HALF_Q16;
  assign mistake = pred != label_q;

  // memory port selection
  always_comb begin
    w_we    = 1'b0;
    w_waddr = upd_addr_q;
    w_wdata = w_sat;
    if (state_q == ST_CLR) begin
      w_we    = 1'b1;
      w_waddr = clr_addr_q;
      w_wdata = '0;
    end else if (state_q == ST_UWWR) begin
      w_we    = 1'b1;
    end
    if (state_q == ST_UWRD) begin
      w_raddr = AW'(b_rdata);
    end else if (state_q == ST_IDLE) begin
      w_raddr = AW'(in_item_i.feature_index);
    end else begin
      w_raddr = AW'(idx_q);
    end
  end

  assign b_we = (state_q == ST_ACC) && (cnt_q < CNT_MAX);

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    idx_d       = idx_q;
    label_d     = label_q;
    last_d      = last_q;
    mod_k_d     = mod_k_q;
    score_d     = score_q;
    cnt_d       = cnt_q;
    upd_i_d     = upd_i_q;
    upd_addr_d  = upd_addr_q;
    ovf_d       = ovf_q;
    step_up_d   = step_up_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_acc;
    out_item_d  = out_item_q;

    unique case (state_q)
      ST_CLR: begin
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          idx_d   = in_item_i.feature_index;
          label_d = in_item_i.label;
          last_d  = in_item_i.last;
          mod_k_d = MOD_FIRST;
          // weight read for an in-range index is already issued this cycle
          if (40'(in_item_i.feature_index) < DIM_W) begin
            state_d = ST_ACC;
          end else begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_ge) begin
          idx_d = idx_q - mod_div[hfpt_pkg::IndexW-1:0];
        end
        mod_k_d = mod_k_q - MKW'(1);
        if (mod_k_q == '0) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        score_d = score_sat;
        if (cnt_q < CNT_MAX) begin
          cnt_d = cnt_q + CW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        state_d = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_item_d.score       = score_q;
          out_item_d.predicted   = pred;
          out_item_d.mistake     = mistake;
          out_item_d.overflow    = ovf_q;
          out_item_d.error_count = total_q;
          score_d                = '0;
          ovf_d                  = 1'b0;
          step_up_d              = label_q;
          upd_i_d                = '0;
          if (mistake && train_en_q) begin
            if (total_q != '1) begin
              total_d                = total_q + hfpt_pkg::CountW'(1);
              out_item_d.error_count = total_q + hfpt_pkg::CountW'(1);
            end
            state_d = (cnt_q != '0) ? ST_UBUF : ST_IDLE;
            if (cnt_q == '0) begin
              cnt_d = '0;
            end
          end else begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      ST_UBUF: begin
        state_d = ST_UWRD;
      end
      ST_UWRD: begin
        upd_addr_d = AW'(b_rdata);
        state_d    = ST_UWWR;
      end
      ST_UWWR: begin
        upd_i_d = upd_i_q + CW'(1);
        if (upd_i_q + CW'(1) == cnt_q) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_UBUF;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_addr_q  <= '0;
      score_q     <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      train_en_q  <= hfpt_pkg::TRAIN_ENABLE_RST;
      step_q      <= hfpt_pkg::UPDATE_STEP_RST;
      mod_k_q     <= '0;
      upd_i_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      score_q     <= score_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      mod_k_q     <= mod_k_d;
      upd_i_q     <= upd_i_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          hfpt_pkg::REG_TRAIN_ENABLE: train_en_q <= cfg_data_i[0];
          hfpt_pkg::REG_UPDATE_STEP:  step_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    label_q    <= label_d;
    last_q     <= last_d;
    upd_addr_q <= upd_addr_d;
    step_up_q  <= step_up_d;
    out_item_q <= out_item_d;
  end

  hfpt_ram #(
    .WIDTH (WW),
    .DEPTH (DIMENSION)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  hfpt_ram #(
    .WIDTH (IDXW),
    .DEPTH (MAX_FEATURES)
  ) u_feature_buf (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (cnt_q[BW-1:0]),
    .wdata_i (IDXW'(idx_q)),
    .raddr_i (upd_i_q[BW-1:0]),
    .rdata_o (b_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("feature count beyond buffer depth");

  a_fin_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |-> cnt_q != '0)
    else $error("example finished with no buffered feature");

  a_clear_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR && state_d != ST_CLR) |-> clr_addr_q == CLR_LAST)
    else $error("clearing pass ended early");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the finish step");

  a_idx_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |-> {24'd0, idx_q} < DIM_W)
    else $error("accumulated index not reduced below DIMENSION");

endmodule

// ----- tb/sv/hashed_feature_perceptron_trainer_unit_chk.sv -----
// ----------------------------------------------------------------------------
// hashed_feature_perceptron_trainer_unit_chk
// Watches the feature, result and register channels of the perceptron
// trainer. It keeps its own weight table and example buffer, works out the
// score, prediction, mistake count and overflow mark of each example, and
// compares every result transaction with the oldest expected one.
// ----------------------------------------------------------------------------
module hashed_feature_perceptron_trainer_unit_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  hfpt_pkg::in_item_t            in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  hfpt_pkg::out_item_t           out_item_i,
  input  logic                          cfg_we_i,
  input  logic [hfpt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hfpt_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WeightHi = 64'sd2147483647;
  localparam longint WeightLo = -64'sd2147483648;
  localparam longint ScoreHi  = 64'sd140737488355327;
  localparam longint ScoreLo  = -64'sd140737488355328;

  logic signed [hfpt_pkg::WeightW-1:0] weights [hfpt_pkg::DIMENSION_DEF];
  logic [hfpt_pkg::IndexW-1:0]         example_idx [$];
  logic signed [hfpt_pkg::ScoreW-1:0]  score_sum;
  logic                                buf_overflow;
  logic [hfpt_pkg::CountW-1:0]         mistake_total;
  logic                                train_en;
  logic [hfpt_pkg::StepW-1:0]          step;
  hfpt_pkg::out_item_t                 expected_results [$];

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void compare_field(string field, logic signed [63:0] want,
                                        logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count_o++;
    end
  endfunction

  function automatic void check_result(hfpt_pkg::out_item_t got);
    hfpt_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result transaction with no expected result");
      fail_count_o++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("score", want.score, got.score);
    compare_field("predicted", {63'd0, want.predicted}, {63'd0, got.predicted});
    compare_field("mistake", {63'd0, want.mistake}, {63'd0, got.mistake});
    compare_field("error_count", {32'd0, want.error_count}, {32'd0, got.error_count});
    compare_field("overflow", {63'd0, want.overflow}, {63'd0, got.overflow});
  endfunction

  function automatic void take_feature(hfpt_pkg::in_item_t it);
    hfpt_pkg::out_item_t r;
    logic [hfpt_pkg::IndexW-1:0] a;
    longint delta;
    a = it.feature_index;  // DIMENSION covers the whole index range
    score_sum = hfpt_pkg::ScoreW'(clamp(longint'(score_sum) + longint'(weights[a]),
                                        ScoreLo, ScoreHi));
    if (example_idx.size() < hfpt_pkg::MAX_FEATURES_DEF) example_idx = {example_idx, a};
    else buf_overflow = 1'b1;
    if (!it.last) return;

    r.score     = score_sum;
    r.predicted = (score_sum > hfpt_pkg::HALF_Q16);
    r.mistake   = (r.predicted != it.label);
    if (r.mistake && train_en) begin
      delta = it.label ? longint'(step) : -longint'(step);
      if (mistake_total != '1) mistake_total++;
      // duplicates move once per occurrence
      foreach (example_idx[i]) begin
        weights[example_idx[i]] =
            hfpt_pkg::WeightW'(clamp(longint'(weights[example_idx[i]]) + delta,
                                     WeightLo, WeightHi));
      end
    end
    r.error_count = mistake_total;
    r.overflow    = buf_overflow;
    expected_results = {expected_results, r};

    example_idx.delete();
    score_sum    = '0;
    buf_overflow = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (weights[i]) weights[i] = '0;
      example_idx.delete();
      expected_results.delete();
      score_sum     = '0;
      buf_overflow  = 1'b0;
      mistake_total = '0;
      train_en      = hfpt_pkg::TRAIN_ENABLE_RST;
      step          = hfpt_pkg::UPDATE_STEP_RST;
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          hfpt_pkg::REG_TRAIN_ENABLE: train_en = cfg_data_i[0];
          hfpt_pkg::REG_UPDATE_STEP:  step = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (in_valid_i && !in_stall_i) take_feature(in_item_i);
      pending_o = expected_results.size();
    end
  end

endmodule

// ----- tb/sv/hashed_feature_perceptron_trainer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// hashed_feature_perceptron_trainer_unit_tb
// Drives feature transactions and register writes into the perceptron
// trainer through several settings of train_enable and update_step, with
// random gaps and stalls on both channels, and reports the verdict from the
// checker's failure count.
// ----------------------------------------------------------------------------
module hashed_feature_perceptron_trainer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // covers the longest replay of a full buffer (buffer read, weight read and weight write per feature)
  localparam int unsigned SettleCycles = 3500;
  localparam int unsigned HoldCycles   = 400;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid;
  logic                          in_stall;
  hfpt_pkg::in_item_t            in_item;
  logic                          out_valid;
  logic                          out_stall;
  hfpt_pkg::out_item_t           out_item;
  logic                          cfg_we;
  logic [hfpt_pkg::CfgIdxW-1:0]  cfg_index;
  logic [hfpt_pkg::CfgDataW-1:0] cfg_data;
  int                            fail_count;
  int                            pending;

  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  always #2 clk_i = ~clk_i;

  hashed_feature_perceptron_trainer_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  hashed_feature_perceptron_trainer_unit_chk chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 16);
      end
    end
  end

  function automatic logic [hfpt_pkg::IndexW-1:0] pick_index(int unsigned hot);
    case ($urandom_range(9))
      0: return $urandom_range(1) ? '1 : '0;
      1, 2: return hfpt_pkg::IndexW'($urandom_range(16'hFFFF));
      default: return hfpt_pkg::IndexW'($urandom_range(hot - 1));
    endcase
  endfunction

  task automatic feed(logic [hfpt_pkg::IndexW-1:0] idx, logic lbl, logic lst);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{feature_index: idx, label: lbl, last: lst};
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic burst(logic [hfpt_pkg::IndexW-1:0] idx, int unsigned len, logic lbl);
    for (int unsigned k = 0; k < len; k++) begin
      feed(idx, (k == len - 1) ? lbl : 1'($urandom_range(1)), k == len - 1);
    end
  endtask

  task automatic send_example(int unsigned len, int unsigned hot);
    logic lbl;
    lbl = 1'($urandom_range(1));
    for (int unsigned k = 0; k < len; k++) begin
      feed(pick_index(hot), (k == len - 1) ? lbl : 1'($urandom_range(1)), k == len - 1);
    end
  endtask

  task automatic run_random(int unsigned count, int unsigned hot);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
      send_example(len, hot);
      sent += len;
    end
  endtask

  // wait out every result and any weight replay behind the last one
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_regs(logic en, logic [hfpt_pkg::StepW-1:0] st);
    cfg_we    <= 1'b1;
    cfg_index <= hfpt_pkg::REG_TRAIN_ENABLE;
    cfg_data  <= {{(hfpt_pkg::CfgDataW-1){1'b0}}, en};
    @(negedge clk_i);
    cfg_index <= hfpt_pkg::REG_UPDATE_STEP;
    cfg_data  <= st;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [hfpt_pkg::IndexW-1:0] sat_idx;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = hfpt_pkg::REG_TRAIN_ENABLE;
    cfg_data  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: extremes of the index, duplicates, both labels
    feed('0, 1'b1, 1'b1);
    feed('1, 1'b0, 1'b1);
    feed('0, 1'b1, 1'b1);
    feed('0, 1'b0, 1'b0);
    feed('0, 1'b1, 1'b0);
    feed('0, 1'b0, 1'b1);
    feed('0, 1'b1, 1'b0);
    feed('1, 1'b0, 1'b0);
    feed('0, 1'b1, 1'b1);
    feed('1, 1'b1, 1'b1);
    feed(16'h5555, 1'b0, 1'b0);
    feed(16'hAAAA, 1'b1, 1'b1);
    run_random(60, 16);
    settle();

    // score of exactly one half predicts 0; no idling in this stretch
    calm = 1'b1;
    write_regs(1'b1, 24'd32768);
    feed(16'd9000, 1'b1, 1'b1);
    feed(16'd9000, 1'b1, 1'b1);
    feed(16'd9000, 1'b0, 1'b1);
    run_random(100, 16);
    settle();
    calm = 1'b0;

    // largest step: one repeated index drives a weight to one of its rails
    write_regs(1'b1, '1);
    sat_idx = pick_index(16);
    burst(sat_idx, $urandom_range(140, 130), 1'b1);
    burst(sat_idx, $urandom_range(140, 130), 1'b0);
    burst(sat_idx, $urandom_range(140, 130), 1'b0);
    run_random(40, 16);
    settle();

    // scoring only
    write_regs(1'b0, hfpt_pkg::StepW'($urandom_range(24'hFFFFFF)));
    run_random(60, 16);
    settle();

    // zero step
    write_regs(1'b1, '0);
    run_random(40, 16);
    settle();

    // moderate step with a long result hold-off, then an overfull buffer
    write_regs(1'b1, hfpt_pkg::StepW'($urandom_range(65535, 1)));
    hold_req = 1'b1;
    run_random(80, 32);
    send_example(hfpt_pkg::MAX_FEATURES_DEF + $urandom_range(6, 1), 4096);
    settle();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/hfpt_pkg.sv
hdl/hfpt_ram.sv
hdl/hashed_feature_perceptron_trainer_unit.sv
tb/sv/hashed_feature_perceptron_trainer_unit_chk.sv
tb/sv/hashed_feature_perceptron_trainer_unit_tb.sv
